/* src/ckpb_pkg.sv */
// ============================================================================
// ckpb_pkg: shared types and constants for the chroma key pixel blend
// Holds field widths, the configuration register codes, the key color type,
// the pipeline stage map defaults and the threshold tables indexed by tolerance.
// ============================================================================
`default_nettype none

package ckpb_pkg;

    // Field widths.
    localparam int PIX_W   = 8;
    localparam int PCT_W   = 7;
    localparam int DIST_W  = 18;             // sum of three squared 8-bit differences
    localparam int FRAC_W  = 16;             // Q16 fraction bits
    localparam int ROOT_W  = DIST_W / 2 + FRAC_W;
    localparam int FQ_W    = 24;             // far threshold in Q16
    localparam int MNUM_W  = 32;             // 255 * (FQ - D)
    localparam int WNUM_W  = 24;             // weight dividend
    localparam int DEN_W   = 16;             // matte * (100 + defringe)
    localparam int WDEN_W  = DEN_W + 1;      // doubled divisor
    localparam int W_W     = FRAC_W + 1;     // weight, at most 1.0 in Q16
    localparam int MATTE_W = 8;
    localparam int CFG_IDX_W = 8;
    localparam int TOL_N   = 1 << PCT_W;

    // Arithmetic constants.
    localparam int          PCT_BASE  = 100;
    localparam logic [23:0] W_NUM_OFS = 24'd13107200;   // 100 * 2^16 * 2
    localparam logic [W_W-1:0] W_ONE  = W_W'(1 << FRAC_W);
    localparam logic [MATTE_W-1:0] MATTE_FG = 8'd255;
    localparam logic [MATTE_W-1:0] MATTE_BG = 8'd0;

    // Default pipeline shape (bits resolved per stage, and the front stage count).
    localparam int SQRT_STEP_DEF = 2;
    localparam int MDIV_STEP_DEF = 2;
    localparam int WDIV_STEP_DEF = 3;
    localparam int FRONT_STAGES  = 4;

    // Configuration register codes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_LOW_LUMA     = 8'd0,
        CFG_KEY_LOW_RED      = 8'd1,
        CFG_KEY_LOW_BLUE     = 8'd2,
        CFG_KEY_HIGH_LUMA    = 8'd3,
        CFG_KEY_HIGH_RED     = 8'd4,
        CFG_KEY_HIGH_BLUE    = 8'd5,
        CFG_TOLERANCE        = 8'd6,
        CFG_DEFRINGE         = 8'd7
    } t_cfg_idx;

    // One key color point in Y, Cr, Cb.
    typedef struct packed {
        logic [PIX_W-1:0] luma;
        logic [PIX_W-1:0] red_diff;
        logic [PIX_W-1:0] blue_diff;
    } t_key;

    typedef logic [TOL_N-1:0][25:0]     t_near_tab;
    typedef logic [TOL_N-1:0][34:0]     t_far_tab;
    typedef logic [TOL_N-1:0][FQ_W-1:0] t_fq_tab;

    // (34 * (100 + t))^2, compared against 10^4 * d^2.
    function automatic t_near_tab build_near();
        t_near_tab tab;
        longint    s;
        for (int i = 0; i < TOL_N; i++) begin
            s      = longint'(PCT_BASE + i);
            tab[i] = 26'((34 * s) * (34 * s));
        end
        return tab;
    endfunction

    // (629 * (100 + t))^2, compared against 10^6 * d^2.
    function automatic t_far_tab build_far();
        t_far_tab tab;
        longint   s;
        for (int i = 0; i < TOL_N; i++) begin
            s      = longint'(PCT_BASE + i);
            tab[i] = 35'((629 * s) * (629 * s));
        end
        return tab;
    endfunction

    // Far threshold in Q16, rounded.
    function automatic t_fq_tab build_fq();
        t_fq_tab tab;
        longint  s;
        for (int i = 0; i < TOL_N; i++) begin
            s      = longint'(PCT_BASE + i);
            tab[i] = FQ_W'((629 * s * 65536 + 500) / 1000);
        end
        return tab;
    endfunction

    localparam t_near_tab NEAR_SQ_TABLE = build_near();
    localparam t_far_tab  FAR_SQ_TABLE  = build_far();
    localparam t_fq_tab   FQ_TABLE      = build_fq();

endpackage

`default_nettype wire

/* src/ckpb_front.sv */
// ============================================================================
// ckpb_front: color conversion and key distance stages
// Four stages: luma, chroma, squared distances to both keys, then the
// nearest distance with its background and foreground threshold tests.
// ============================================================================
`default_nettype none

module ckpb_front (
    input  wire logic                             i_clk,
    input  wire logic [ckpb_pkg::FRONT_STAGES-1:0] i_en,
    input  wire logic [ckpb_pkg::PIX_W-1:0]       i_blue,
    input  wire logic [ckpb_pkg::PIX_W-1:0]       i_green,
    input  wire logic [ckpb_pkg::PIX_W-1:0]       i_red,
    input  wire ckpb_pkg::t_key                   i_key_low,
    input  wire ckpb_pkg::t_key                   i_key_high,
    input  wire logic [ckpb_pkg::PCT_W-1:0]       i_tolerance,
    output logic [ckpb_pkg::DIST_W-1:0]           o_dmin,
    output logic                                  o_bg,
    output logic                                  o_fg,
    output logic [ckpb_pkg::FQ_W-1:0]             o_fq,
    output logic [ckpb_pkg::PIX_W-1:0]            o_blue,
    output logic [ckpb_pkg::PIX_W-1:0]            o_green,
    output logic [ckpb_pkg::PIX_W-1:0]            o_red
);
    import ckpb_pkg::*;

    // Chroma from a component and luma, clamped to 0..255.
    function automatic logic [PIX_W-1:0] chroma(input logic [PIX_W-1:0] comp,
                                                input logic [PIX_W-1:0] luma,
                                                input logic [14:0] coef);
        logic signed [9:0]  diff;
        logic signed [25:0] v;
        logic [9:0]         c;
        diff = $signed({2'b00, comp}) - $signed({2'b00, luma});
        v    = 26'(diff) * $signed({11'd0, coef}) + 26'sd6299648;
        c    = v[23:14];
        if (c < 10'd256) begin
            return '0;
        end else if (c > 10'd511) begin
            return 8'hFF;
        end
        return c[7:0];
    endfunction

    function automatic logic [DIST_W-1:0] dist_sq(input logic [PIX_W-1:0] a0,
                                                  input logic [PIX_W-1:0] a1,
                                                  input logic [PIX_W-1:0] a2,
                                                  input t_key k);
        logic [PIX_W-1:0] d0, d1, d2;
        d0 = (a0 > k.luma)      ? a0 - k.luma      : k.luma - a0;
        d1 = (a1 > k.red_diff)  ? a1 - k.red_diff  : k.red_diff - a1;
        d2 = (a2 > k.blue_diff) ? a2 - k.blue_diff : k.blue_diff - a2;
        return DIST_W'(16'(d0) * 16'(d0)) + DIST_W'(16'(d1) * 16'(d1))
             + DIST_W'(16'(d2) * 16'(d2));
    endfunction

    logic [PIX_W-1:0]  r_b0, r_g0, r_r0, r_y0;
    logic [PIX_W-1:0]  r_b1, r_g1, r_r1, r_y1, r_cr1, r_cb1;
    logic [PIX_W-1:0]  r_b2, r_g2, r_r2;
    logic [DIST_W-1:0] r_dl2, r_dh2;
    logic [23:0]       w_ysum;
    logic [DIST_W-1:0] w_dmin;

    // Weighted luma sum with rounding.
    assign w_ysum = 24'(i_red) * 24'd4899 + 24'(i_green) * 24'd9617
                  + 24'(i_blue) * 24'd1868 + 24'd8192;

    assign w_dmin = (r_dl2 < r_dh2) ? r_dl2 : r_dh2;

    // Stage 0: luma.
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_b0 <= i_blue;
            r_g0 <= i_green;
            r_r0 <= i_red;
            r_y0 <= w_ysum[21:14];
        end
    end

    // Stage 1: red and blue color differences.
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_b1  <= r_b0;
            r_g1  <= r_g0;
            r_r1  <= r_r0;
            r_y1  <= r_y0;
            r_cr1 <= chroma(r_r0, r_y0, 15'd11682);
            r_cb1 <= chroma(r_b0, r_y0, 15'd9241);
        end
    end

    // Stage 2: squared distances to both key points.
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_b2  <= r_b1;
            r_g2  <= r_g1;
            r_r2  <= r_r1;
            r_dl2 <= dist_sq(r_y1, r_cr1, r_cb1, i_key_low);
            r_dh2 <= dist_sq(r_y1, r_cr1, r_cb1, i_key_high);
        end
    end

    // Stage 3: nearest distance against both thresholds.
    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            o_blue  <= r_b2;
            o_green <= r_g2;
            o_red   <= r_r2;
            o_dmin  <= w_dmin;
            o_bg    <= (32'(w_dmin) * 32'd10000) < 32'(NEAR_SQ_TABLE[i_tolerance]);
            o_fg    <= (40'(w_dmin) * 40'd1000000) > 40'(FAR_SQ_TABLE[i_tolerance]);
            o_fq    <= FQ_TABLE[i_tolerance];
        end
    end

endmodule

`default_nettype wire

/* src/ckpb_sqrt.sv */
// ============================================================================
// ckpb_sqrt: pipelined square root in Q16
// Digit-by-digit restoring square root of the radicand shifted left by
// twice the fraction width; STEP result bits are resolved per stage.
// ============================================================================
`default_nettype none

module ckpb_sqrt #(
    parameter int RAD_W = ckpb_pkg::DIST_W,
    parameter int FRAC  = ckpb_pkg::FRAC_W,
    parameter int STEP  = ckpb_pkg::SQRT_STEP_DEF,
    parameter int SB_W  = 8
) (
    input  wire logic                                         i_clk,
    input  wire logic [(RAD_W/2+FRAC+STEP-1)/STEP-1:0]        i_en,
    input  wire logic [RAD_W-1:0]                             i_rad,
    input  wire logic [SB_W-1:0]                              i_sb,
    output logic [RAD_W/2+FRAC-1:0]                           o_root,
    output logic [SB_W-1:0]                                   o_sb
);
    import ckpb_pkg::*;

    localparam int RT_W = RAD_W / 2 + FRAC;
    localparam int NST  = (RT_W + STEP - 1) / STEP;
    localparam int R_W  = RT_W + 2;

    logic [R_W-1:0]   r_rem  [NST];
    logic [RT_W-1:0]  r_root [NST];
    logic [RAD_W-1:0] r_rad  [NST];
    logic [SB_W-1:0]  r_sb   [NST];

    for (genvar s = 0; s < NST; s++) begin : g_stage
        logic [R_W-1:0]   w_rem_in, n_rem;
        logic [RT_W-1:0]  w_root_in, n_root;
        logic [RAD_W-1:0] w_rad_in;
        logic [SB_W-1:0]  w_sb_in;
        logic [R_W+1:0]   w_acc;
        logic [1:0]       w_pair;

        if (s == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_root_in = '0;
            assign w_rad_in  = i_rad;
            assign w_sb_in   = i_sb;
        end else begin : g_next
            assign w_rem_in  = r_rem[s-1];
            assign w_root_in = r_root[s-1];
            assign w_rad_in  = r_rad[s-1];
            assign w_sb_in   = r_sb[s-1];
        end

        // Resolve STEP root bits, two radicand bits each.
        always_comb begin
            n_rem  = w_rem_in;
            n_root = w_root_in;
            w_acc  = '0;
            w_pair = '0;
            for (int j = 0; j < STEP; j++) begin
                if (RT_W - 1 - s * STEP - j >= 0) begin
                    if (RT_W - 1 - s * STEP - j >= FRAC) begin
                        w_pair = 2'(w_rad_in >> (2 * (RT_W - 1 - s * STEP - j - FRAC)));
                    end else begin
                        w_pair = 2'b00;
                    end
                    w_acc = {n_rem, w_pair};
                    if (w_acc >= {2'b00, n_root, 2'b01}) begin
                        n_rem  = R_W'(w_acc - {2'b00, n_root, 2'b01});
                        n_root = {n_root[RT_W-2:0], 1'b1};
                    end else begin
                        n_rem  = R_W'(w_acc);
                        n_root = {n_root[RT_W-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[s]) begin
                r_rem[s]  <= n_rem;
                r_root[s] <= n_root;
                r_rad[s]  <= w_rad_in;
                r_sb[s]   <= w_sb_in;
            end
        end
    end

    assign o_root = r_root[NST-1];
    assign o_sb   = r_sb[NST-1];

endmodule

`default_nettype wire

/* src/ckpb_div.sv */
// ============================================================================
// ckpb_div: pipelined restoring divider
// Unsigned quotient of Q_W bits, STEP quotient bits per stage. The dividend
// must be below the divisor shifted left by Q_W.
// ============================================================================
`default_nettype none

module ckpb_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 24,
    parameter int Q_W   = 8,
    parameter int STEP  = 2,
    parameter int SB_W  = 8
) (
    input  wire logic                              i_clk,
    input  wire logic [(Q_W+STEP-1)/STEP-1:0]      i_en,
    input  wire logic [NUM_W-1:0]                  i_num,
    input  wire logic [DEN_W-1:0]                  i_den,
    input  wire logic [SB_W-1:0]                   i_sb,
    output logic [Q_W-1:0]                         o_q,
    output logic [SB_W-1:0]                        o_sb
);
    import ckpb_pkg::*;

    localparam int NST = (Q_W + STEP - 1) / STEP;
    localparam int CW  = DEN_W + Q_W;

    logic [NUM_W-1:0] r_rem [NST];
    logic [Q_W-1:0]   r_q   [NST];
    logic [DEN_W-1:0] r_den [NST];
    logic [SB_W-1:0]  r_sb  [NST];

    for (genvar s = 0; s < NST; s++) begin : g_stage
        logic [NUM_W-1:0] w_rem_in, n_rem;
        logic [Q_W-1:0]   w_q_in, n_q;
        logic [DEN_W-1:0] w_den_in;
        logic [SB_W-1:0]  w_sb_in;
        logic [CW-1:0]    w_sub, w_rx;

        if (s == 0) begin : g_first
            assign w_rem_in = i_num;
            assign w_q_in   = '0;
            assign w_den_in = i_den;
            assign w_sb_in  = i_sb;
        end else begin : g_next
            assign w_rem_in = r_rem[s-1];
            assign w_q_in   = r_q[s-1];
            assign w_den_in = r_den[s-1];
            assign w_sb_in  = r_sb[s-1];
        end

        // Compare and subtract for each quotient bit of this stage.
        always_comb begin
            n_rem = w_rem_in;
            n_q   = w_q_in;
            w_sub = '0;
            w_rx  = '0;
            for (int j = 0; j < STEP; j++) begin
                if (Q_W - 1 - s * STEP - j >= 0) begin
                    w_sub = CW'(w_den_in) << (Q_W - 1 - s * STEP - j);
                    w_rx  = CW'(n_rem);
                    if (w_rx >= w_sub) begin
                        n_rem = NUM_W'(w_rx - w_sub);
                        n_q   = n_q | (Q_W'(1) << (Q_W - 1 - s * STEP - j));
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[s]) begin
                r_rem[s] <= n_rem;
                r_q[s]   <= n_q;
                r_den[s] <= w_den_in;
                r_sb[s]  <= w_sb_in;
            end
        end
    end

    assign o_q  = r_q[NST-1];
    assign o_sb = r_sb[NST-1];

endmodule

`default_nettype wire

/* src/ckpb_blend.sv */
// ============================================================================
// ckpb_blend: final composite stage
// Keeps the pixel for foreground, substitutes blue for background, and mixes
// partial pixels toward blue with the Q16 weight, rounded and saturated.
// ============================================================================
`default_nettype none

module ckpb_blend (
    input  wire logic                           i_clk,
    input  wire logic                           i_en,
    input  wire logic [ckpb_pkg::W_W-1:0]       i_weight,
    input  wire logic [ckpb_pkg::MATTE_W-1:0]   i_matte,
    input  wire logic [ckpb_pkg::PIX_W-1:0]     i_blue,
    input  wire logic [ckpb_pkg::PIX_W-1:0]     i_green,
    input  wire logic [ckpb_pkg::PIX_W-1:0]     i_red,
    output logic [ckpb_pkg::MATTE_W-1:0]        o_matte,
    output logic [ckpb_pkg::PIX_W-1:0]          o_blue,
    output logic [ckpb_pkg::PIX_W-1:0]          o_green,
    output logic [ckpb_pkg::PIX_W-1:0]          o_red
);
    import ckpb_pkg::*;

    function automatic logic [PIX_W-1:0] sat(input logic [25:0] v);
        logic [9:0] s;
        s = v[25:16];
        return (s > 10'd255) ? 8'hFF : s[7:0];
    endfunction

    logic [W_W-1:0] w_w;
    logic [25:0]    w_sb, w_sg, w_sr;

    // Weighted sums with the blue key color.
    assign w_w  = (i_weight > W_ONE) ? W_ONE : i_weight;
    assign w_sb = 26'(w_w) * 26'(i_blue) + 26'(W_ONE - w_w) * 26'd255 + 26'd32768;
    assign w_sg = 26'(w_w) * 26'(i_green) + 26'd32768;
    assign w_sr = 26'(w_w) * 26'(i_red) + 26'd32768;

    // Output register.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_matte <= i_matte;
            if (i_matte == MATTE_FG) begin
                o_blue  <= i_blue;
                o_green <= i_green;
                o_red   <= i_red;
            end else if (i_matte == MATTE_BG) begin
                o_blue  <= 8'hFF;
                o_green <= '0;
                o_red   <= '0;
            end else begin
                o_blue  <= sat(w_sb);
                o_green <= sat(w_sg);
                o_red   <= sat(w_sr);
            end
        end
    end

endmodule

`default_nettype wire

/* src/chroma_key_pixel_blend_top.sv */
// ============================================================================
// chroma_key_pixel_blend_top: chroma key matte and composite, one pixel a clock
// Pipeline of front end, square root, matte divider, weight divider and blend.
// ============================================================================
// One BGR pixel enters per clock unless the output stalls; its matte and
// composited pixel pass, with the default settings, through 4 conversion and
// distance stages, 13 square root stages, one scaling stage, 4 matte divider
// stages, one weight stage, 6 weight divider stages and the output register.
// The latency follows from the bits resolved per stage in the square root and
// the two dividers. Every stage has its own valid bit and moves whenever the
// stage after it is empty or moving, so bubbles close up under output
// back-pressure and the input keeps accepting until all stages are full.
// Write configuration only while no pixel is in flight; writes complete in the
// cycle they are presented, and indexes past the register list are ignored.
`default_nettype none

module chroma_key_pixel_blend_top #(
    parameter int SQRT_STEP = ckpb_pkg::SQRT_STEP_DEF,
    parameter int MDIV_STEP = ckpb_pkg::MDIV_STEP_DEF,
    parameter int WDIV_STEP = ckpb_pkg::WDIV_STEP_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic [ckpb_pkg::PIX_W-1:0]       i_in_blue,
    input  wire logic [ckpb_pkg::PIX_W-1:0]       i_in_green,
    input  wire logic [ckpb_pkg::PIX_W-1:0]       i_in_red,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic [ckpb_pkg::MATTE_W-1:0]          o_matte,
    output logic [ckpb_pkg::PIX_W-1:0]            o_out_blue,
    output logic [ckpb_pkg::PIX_W-1:0]            o_out_green,
    output logic [ckpb_pkg::PIX_W-1:0]            o_out_red,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [ckpb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [ckpb_pkg::PIX_W-1:0]       i_cfg_data
);
    import ckpb_pkg::*;

    // Stage map.
    localparam int N_SQRT   = (ROOT_W + SQRT_STEP - 1) / SQRT_STEP;
    localparam int N_MDIV   = (MATTE_W + MDIV_STEP - 1) / MDIV_STEP;
    localparam int N_WDIV   = (W_W + WDIV_STEP - 1) / WDIV_STEP;
    localparam int ST_SQRT  = FRONT_STAGES;
    localparam int ST_NUM   = ST_SQRT + N_SQRT;
    localparam int ST_MDIV  = ST_NUM + 1;
    localparam int ST_MATTE = ST_MDIV + N_MDIV;
    localparam int ST_WDIV  = ST_MATTE + 1;
    localparam int ST_BLEND = ST_WDIV + N_WDIV;
    localparam int N_ST     = ST_BLEND + 1;

    localparam int SQ_SB_W = 3 * PIX_W + 2 + FQ_W;
    localparam int MD_SB_W = 3 * PIX_W + 2;
    localparam int WD_SB_W = 3 * PIX_W + MATTE_W;

    // Configuration registers.
    t_key             r_key_low, r_key_high;
    logic [PCT_W-1:0] r_tolerance, r_defringe;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low   <= '0;
            r_key_high  <= '0;
            r_tolerance <= '0;
            r_defringe  <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_KEY_LOW_LUMA:  r_key_low.luma       <= i_cfg_data;
                CFG_KEY_LOW_RED:   r_key_low.red_diff   <= i_cfg_data;
                CFG_KEY_LOW_BLUE:  r_key_low.blue_diff  <= i_cfg_data;
                CFG_KEY_HIGH_LUMA: r_key_high.luma      <= i_cfg_data;
                CFG_KEY_HIGH_RED:  r_key_high.red_diff  <= i_cfg_data;
                CFG_KEY_HIGH_BLUE: r_key_high.blue_diff <= i_cfg_data;
                CFG_TOLERANCE:     r_tolerance          <= i_cfg_data[PCT_W-1:0];
                CFG_DEFRINGE:      r_defringe           <= i_cfg_data[PCT_W-1:0];
                default: ;
            endcase
        end
    end

    // Per-stage valid bits and enables; a stage loads when it is empty or
    // the stage after it loads.
    logic [N_ST-1:0] r_valid;
    logic [N_ST:0]   w_en;

    always_comb begin
        w_en[N_ST] = i_out_ready;
        for (int k = N_ST - 1; k >= 0; k--) begin
            w_en[k] = !r_valid[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int k = 0; k < N_ST; k++) begin
                if (w_en[k]) begin
                    r_valid[k] <= (k == 0) ? i_in_valid : r_valid[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_valid[N_ST-1];

    // Color conversion and thresholds.
    logic [DIST_W-1:0] w_dmin;
    logic              w_bg, w_fg;
    logic [FQ_W-1:0]   w_fq;
    logic [PIX_W-1:0]  w_fb, w_fgr, w_fr;

    ckpb_front u_front (
        .i_clk       (i_clk),
        .i_en        (w_en[FRONT_STAGES-1:0]),
        .i_blue      (i_in_blue),
        .i_green     (i_in_green),
        .i_red       (i_in_red),
        .i_key_low   (r_key_low),
        .i_key_high  (r_key_high),
        .i_tolerance (r_tolerance),
        .o_dmin      (w_dmin),
        .o_bg        (w_bg),
        .o_fg        (w_fg),
        .o_fq        (w_fq),
        .o_blue      (w_fb),
        .o_green     (w_fgr),
        .o_red       (w_fr)
    );

    // Distance square root in Q16.
    logic [ROOT_W-1:0]  w_root;
    logic [SQ_SB_W-1:0] w_sq_sb;

    ckpb_sqrt #(
        .RAD_W (DIST_W),
        .FRAC  (FRAC_W),
        .STEP  (SQRT_STEP),
        .SB_W  (SQ_SB_W)
    ) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en[ST_NUM-1:ST_SQRT]),
        .i_rad  (w_dmin),
        .i_sb   ({w_fb, w_fgr, w_fr, w_bg, w_fg, w_fq}),
        .o_root (w_root),
        .o_sb   (w_sq_sb)
    );

    // Ramp numerator 255 * max(FQ - D, 0).
    logic [FQ_W-1:0]    w_sq_fq, w_diff;
    logic [MNUM_W-1:0]  r_mnum;
    logic [FQ_W-1:0]    r_mfq;
    logic [MD_SB_W-1:0] r_msb;

    assign w_sq_fq = w_sq_sb[FQ_W-1:0];
    assign w_diff  = (ROOT_W'(w_sq_fq) > w_root) ? FQ_W'(ROOT_W'(w_sq_fq) - w_root) : '0;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_NUM]) begin
            r_mnum <= MNUM_W'(w_diff) * MNUM_W'(255);
            r_mfq  <= w_sq_fq;
            r_msb  <= w_sq_sb[SQ_SB_W-1:FQ_W];
        end
    end

    // Matte ramp divider.
    logic [MATTE_W-1:0] w_mq;
    logic [MD_SB_W-1:0] w_md_sb;

    ckpb_div #(
        .NUM_W (MNUM_W),
        .DEN_W (FQ_W),
        .Q_W   (MATTE_W),
        .STEP  (MDIV_STEP),
        .SB_W  (MD_SB_W)
    ) u_mdiv (
        .i_clk (i_clk),
        .i_en  (w_en[ST_MATTE-1:ST_MDIV]),
        .i_num (r_mnum),
        .i_den (r_mfq),
        .i_sb  (r_msb),
        .o_q   (w_mq),
        .o_sb  (w_md_sb)
    );

    // Matte selection and blend divisor.
    logic               w_md_bg, w_md_fg;
    logic [MATTE_W-1:0] w_matte;
    logic [DEN_W-1:0]   w_den;
    logic [WNUM_W-1:0]  r_wnum;
    logic [WDEN_W-1:0]  r_wden;
    logic [WD_SB_W-1:0] r_wsb;

    assign w_md_bg = w_md_sb[1];
    assign w_md_fg = w_md_sb[0];

    always_comb begin
        priority if (w_md_bg) begin
            w_matte = MATTE_BG;
        end else if (w_md_fg) begin
            w_matte = MATTE_FG;
        end else begin
            w_matte = w_mq;
        end
    end

    assign w_den = DEN_W'(w_matte) * DEN_W'(PCT_BASE + 32'(r_defringe));

    always_ff @(posedge i_clk) begin
        if (w_en[ST_MATTE]) begin
            r_wnum <= W_NUM_OFS + WNUM_W'(w_den);
            r_wden <= {w_den, 1'b0};
            r_wsb  <= {w_md_sb[MD_SB_W-1:2], w_matte};
        end
    end

    // Blend weight divider.
    logic [W_W-1:0]     w_wq;
    logic [WD_SB_W-1:0] w_wd_sb;

    ckpb_div #(
        .NUM_W (WNUM_W),
        .DEN_W (WDEN_W),
        .Q_W   (W_W),
        .STEP  (WDIV_STEP),
        .SB_W  (WD_SB_W)
    ) u_wdiv (
        .i_clk (i_clk),
        .i_en  (w_en[ST_BLEND-1:ST_WDIV]),
        .i_num (r_wnum),
        .i_den (r_wden),
        .i_sb  (r_wsb),
        .o_q   (w_wq),
        .o_sb  (w_wd_sb)
    );

    ckpb_blend u_blend (
        .i_clk    (i_clk),
        .i_en     (w_en[ST_BLEND]),
        .i_weight (w_wq),
        .i_matte  (w_wd_sb[MATTE_W-1:0]),
        .i_blue   (w_wd_sb[WD_SB_W-1 -: PIX_W]),
        .i_green  (w_wd_sb[WD_SB_W-PIX_W-1 -: PIX_W]),
        .i_red    (w_wd_sb[WD_SB_W-2*PIX_W-1 -: PIX_W]),
        .o_matte  (o_matte),
        .o_blue   (o_out_blue),
        .o_green  (o_out_green),
        .o_red    (o_out_red)
    );

    // Background results always leave as pure blue.
    a_bg_blue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_matte == MATTE_BG) |->
            (o_out_blue == 8'hFF) && (o_out_green == 8'h00) && (o_out_red == 8'h00))
        else $error("background pixel not replaced by blue");

    // Background and foreground tests never both hold for one pixel.
    a_bg_fg_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[ST_MATTE-1] |-> !(w_md_bg && w_md_fg))
        else $error("pixel flagged as both background and foreground");

    // A partial pixel's weight never exceeds one.
    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[ST_BLEND-1] && (w_wd_sb[MATTE_W-1:0] != MATTE_BG)
            && (w_wd_sb[MATTE_W-1:0] != MATTE_FG) |-> (w_wq <= W_ONE))
        else $error("blend weight above one");

    // Input is taken only when the pipeline has room or is draining.
    a_ready_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (!(&r_valid) || i_out_ready))
        else $error("input accepted into a full stalled pipeline");

endmodule

`default_nettype wire

/* tb/chroma_key_pixel_blend_top_tb.sv */
// ============================================================================
// chroma_key_pixel_blend_top_tb: self-checking bench for the chroma key blend
// Drives pixels and register writes over valid/ready channels, predicts the
// matte and composited pixel of every accepted transaction and checks each
// output transaction in order, under several idle and stall patterns.
// ============================================================================
`default_nettype none

// Keeps the expected matte and pixels of accepted transactions.
class ckpb_blend_scoreboard;
    logic [31:0] pending[$];
    int          mismatches;

    function void note_pixel(logic [31:0] expected_word);
        pending.push_back(expected_word);
    endfunction

    function void check_pixel(logic [31:0] actual_word);
        logic [31:0] expected_word;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected output transaction %h", actual_word);
        end else begin
            expected_word = pending.pop_front();
            if (expected_word !== actual_word) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch matte/b/g/r: expected %h actual %h",
                             expected_word, actual_word);
            end
        end
    endfunction
endclass

module chroma_key_pixel_blend_top_tb;
    import ckpb_pkg::*;

    localparam int LATENCY     = 30;
    localparam int STALL_LIMIT = 20000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_in_blue, i_in_green, i_in_red;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [7:0] o_matte, o_out_blue, o_out_green, o_out_red;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_index;
    logic [7:0] i_cfg_data;

    // Predictor copy of the registers.
    logic [7:0] key_regs[6];
    logic [6:0] tol_pct, dfr_pct;

    int  send_idle_pct, recv_stall_pct, hold_cycles, idle_count;
    bit  timed_out;
    ckpb_blend_scoreboard board;

    chroma_key_pixel_blend_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_in_blue(i_in_blue), .i_in_green(i_in_green), .i_in_red(i_in_red),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_matte(o_matte), .o_out_blue(o_out_blue),
        .o_out_green(o_out_green), .o_out_red(o_out_red),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint unsigned root_floor(longint unsigned x);
        longint unsigned res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x   -= res + bitv;
                res  = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint chroma_level(longint c, longint y, longint coef);
        longint v;
        v = ((c - y) * coef + (384 << 14) + 8192) >>> 14;
        v = v - 256;
        return (v < 0) ? 0 : (v > 255 ? 255 : v);
    endfunction

    function automatic longint key_dist_sq(longint y, longint cr, longint cb, int k);
        longint a, b, c;
        a = y - key_regs[k];
        b = cr - key_regs[k + 1];
        c = cb - key_regs[k + 2];
        return a * a + b * b + c * c;
    endfunction

    function automatic longint mix_level(longint w, longint pix, longint keyc);
        longint v;
        v = (w * pix + (65536 - w) * keyc + 32768) >> 16;
        return v > 255 ? 255 : v;
    endfunction

    // Expected matte and composited pixel, packed as matte, B, G, R.
    function automatic logic [31:0] composite_pixel(logic [7:0] b, logic [7:0] g,
                                                    logic [7:0] r);
        longint y, cr, cb, dl, dh, dmin, scale, near_t, far_t, dq, fq, m, den, w;
        y  = (longint'(r) * 4899 + longint'(g) * 9617 + longint'(b) * 1868 + 8192) >> 14;
        cr = chroma_level(r, y, 11682);
        cb = chroma_level(b, y, 9241);
        dl = key_dist_sq(y, cr, cb, 0);
        dh = key_dist_sq(y, cr, cb, 3);
        dmin   = dl < dh ? dl : dh;
        scale  = 100 + tol_pct;
        near_t = 34 * scale;
        far_t  = 629 * scale;
        if (dmin * 10000 < near_t * near_t) begin
            m = 0;
        end else if (dmin * 1000000 > far_t * far_t) begin
            m = 255;
        end else begin
            dq = longint'(root_floor(longint'(dmin) << 32));
            fq = (far_t * 65536 + 500) / 1000;
            m  = (255 * (fq > dq ? fq - dq : 0)) / fq;
            if (m > 255) m = 255;
        end
        if (m == 255) return {8'd255, b, g, r};
        if (m == 0) return {8'd0, 8'd255, 8'd0, 8'd0};
        den = m * (100 + dfr_pct);
        w   = (13107200 + den) / (2 * den);
        if (w > 65536) w = 65536;
        return {m[7:0], 8'(mix_level(w, b, 255)), 8'(mix_level(w, g, 0)),
                8'(mix_level(w, r, 0))};
    endfunction

    // Write one configuration register and mirror it.
    task automatic write_reg(t_cfg_idx idx, logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_TOLERANCE: tol_pct = data[6:0];
            CFG_DEFRINGE:  dfr_pct = data[6:0];
            default:       key_regs[int'(idx)] = data;
        endcase
        @(posedge i_clk);
    endtask

    // Offer one pixel with optional idle gap before it; valid stays high
    // between back-to-back transactions.
    task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_blue  <= b;
        i_in_green <= g;
        i_in_red   <= r;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_pixel(composite_pixel(b, g, r));
    endtask

    // Let all pending transactions drain before touching the registers.
    task automatic drain;
        i_in_valid <= 1'b0;
        while (board.pending.size() != 0 && !timed_out) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // Random pixel with each component drawn uniformly over its full range.
    task automatic send_random_pixel;
        logic [7:0] b, g, r;
        b = $urandom_range(255);
        g = $urandom_range(255);
        r = $urandom_range(255);
        send_pixel(b, g, r);
    endtask

    // Receiver: random stalls plus one long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Output checking and progress watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                board.check_pixel({o_matte, o_out_blue, o_out_green, o_out_red});
            if ((o_out_valid && i_out_ready) || (i_in_valid && o_in_ready) ||
                (i_cfg_valid && o_cfg_ready))
                idle_count <= 0;
            else
                idle_count <= idle_count + 1;
            if (idle_count > STALL_LIMIT && !timed_out) begin
                timed_out = 1'b1;
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Key points from a colour so that pixels of that colour sit on the key.
    task automatic key_from(int base, logic [7:0] b, logic [7:0] g, logic [7:0] r);
        longint y;
        y = (longint'(r) * 4899 + longint'(g) * 9617 + longint'(b) * 1868 + 8192) >> 14;
        write_reg(t_cfg_idx'(base), y[7:0]);
        write_reg(t_cfg_idx'(base + 1), 8'(chroma_level(r, y, 11682)));
        write_reg(t_cfg_idx'(base + 2), 8'(chroma_level(b, y, 9241)));
    endtask

    initial begin
        board          = new();
        timed_out      = 1'b0;
        idle_count     = 0;
        hold_cycles    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_blue      = '0;
        i_in_green     = '0;
        i_in_red       = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        foreach (key_regs[k]) key_regs[k] = '0;
        tol_pct = '0;
        dfr_pct = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with reset registers: extremes and field bits.
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'h55, 8'hAA, 8'h55);
        send_pixel(8'hAA, 8'h55, 8'hAA);
        drain();

        // Green keys with extreme tolerance and defringe; ramp and background.
        key_from(0, 8'd0, 8'd255, 8'd0);
        key_from(3, 8'd40, 8'd200, 8'd40);
        write_reg(CFG_TOLERANCE, 8'd100);
        write_reg(CFG_DEFRINGE, 8'd100);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd20, 8'd230, 8'd20);
        send_pixel(8'd60, 8'd190, 8'd60);
        send_pixel(8'd90, 8'd160, 8'd90);
        send_pixel(8'd120, 8'd140, 8'd110);
        send_pixel(8'd0, 8'd0, 8'd255);
        drain();
        // Registers above their stated range; index past the list is ignored.
        write_reg(CFG_TOLERANCE, 8'd127);
        write_reg(CFG_DEFRINGE, 8'd127);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= 8'd200;
        i_cfg_data  <= 8'd99;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        send_pixel(8'd70, 8'd180, 8'd70);
        send_pixel(8'd100, 8'd150, 8'd100);
        drain();

        // Random phases over several settings and idle patterns.
        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            key_from(0, 8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)));
            key_from(3, 8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)));
            write_reg(CFG_TOLERANCE, (phase == 0) ? 8'd0 : 8'($urandom_range(100)));
            write_reg(CFG_DEFRINGE, (phase == 0) ? 8'd0 : 8'($urandom_range(100)));
            if (phase == 2) hold_cycles = 200;
            for (int n = 0; n < 185; n++) begin
                // Three in four pixels go this way; on even n they are pushed toward green.
                if ($urandom_range(3) != 0) begin
                    logic [7:0] b, g, r;
                    b = 8'($urandom_range(255));
                    g = 8'($urandom_range(255));
                    r = 8'($urandom_range(255));
                    if (n % 2 == 0) begin
                        g = 8'(g | 8'hC0);
                        b = 8'(b >> 2);
                        r = 8'(r >> 2);
                    end
                    send_pixel(b, g, r);
                end else begin
                    send_random_pixel();
                end
            end
            drain();
        end

        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

`default_nettype wire

/* filelist.f */
src/ckpb_pkg.sv
src/ckpb_front.sv
src/ckpb_sqrt.sv
src/ckpb_div.sv
src/ckpb_blend.sv
src/chroma_key_pixel_blend_top.sv
tb/chroma_key_pixel_blend_top_tb.sv
